@@ rtl/core/ipatp_pkg.sv @@
// ip address text parser: shared types, codes and character helpers
// no dependencies
`timescale 1ns / 1ps

package ipatp_pkg;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SYNTAX  = 2'd1,
    STATUS_ZONE_NA = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_DEC   = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_DOT   = 2'd3
  } mode_t;

  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // parser state carried from one character to the next
  typedef struct packed {
    logic [7:0][15:0] groups;
    logic [3:0]       gidx;
    logic [15:0]      hacc;
    logic [2:0]       gcnt;
    logic [2:0]       cpos;
    logic             cvalid;
    logic             seen_colon;
    logic             prev_colon;
    logic [8:0]       oacc;
    logic [1:0]       ocnt;
    logic [31:0]      v4;
    mode_t            mode;
    logic             in_zone;
    logic [7:0]       zcnt;
    status_t          err;
  } pstate_t;

  typedef struct packed {
    status_t     status;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        has_zone;
    logic [7:0]  zone_length;
  } result_t;

  // hex digit value, bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

@@ rtl/core/ip_address_text_parser_top.sv @@
// ip address text parser top level: handshakes, state and result registers
// depends on ipatp_pkg and ipatp_step
// latency: result valid the cycle after the last character beat is taken
// throughput: one character per cycle, a result register with stall-through
// ready while the result register is empty or being drained
// reset (synchronous, active high) clears the parse state, reject_zone and out_valid
`timescale 1ns / 1ps

module ip_address_text_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        is_ipv6,
  output logic [63:0] addr_high,
  output logic [63:0] addr_low,
  output logic        has_zone,
  output logic [7:0]  zone_length
);
  import ipatp_pkg::*;

  pstate_t st;
  pstate_t st_next;
  result_t res_next;
  result_t res;
  logic    reject_zone;
  logic    take;

  ipatp_step u_step (
    .cur        (st),
    .char_code  (char_code),
    .last_char  (last_char),
    .reject_zone(reject_zone),
    .nxt        (st_next),
    .res        (res_next)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      reject_zone <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) reject_zone <= cfg_data;
      if (take) st <= st_next;
      if (take && last_char) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_char) res <= res_next;
  end

  assign status      = res.status;
  assign is_ipv6     = res.is_ipv6;
  assign addr_high   = res.addr_high;
  assign addr_low    = res.addr_low;
  assign has_zone    = res.has_zone;
  assign zone_length = res.zone_length;

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken over full result");
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    take && last_char |=> out_valid) else $error("missing result");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    take && last_char |=> st.gidx == 4'd0 && !st.in_zone) else $error("state not cleared");
  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> addr_high == '0 && addr_low == '0)
    else $error("address on error");

endmodule

@@ rtl/core/ipatp_step.sv @@
// ip address text parser: next parser state and result for one character
// depends on ipatp_pkg
`timescale 1ns / 1ps

module ipatp_step (
  input  ipatp_pkg::pstate_t cur,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  input  logic               reject_zone,
  output ipatp_pkg::pstate_t nxt,
  output ipatp_pkg::result_t res
);
  import ipatp_pkg::*;

  pstate_t    s;
  pstate_t    f;
  logic [4:0] hv;
  logic [3:0] v;
  logic [11:0] o10;
  logic [3:0] zsz;
  logic [3:0] gsel;
  logic [15:0] word;
  logic [127:0] full;

  // commit of the current hex group
  function automatic pstate_t commit(input pstate_t a, output logic ok);
    pstate_t b;
    b = a;
    ok = (a.gcnt <= 3'd4) && (a.gidx < 4'd8);
    if (ok) begin
      b.groups[a.gidx[2:0]] = a.hacc;
      b.gidx = a.gidx + 4'd1;
      b.hacc = '0;
      b.gcnt = '0;
      b.oacc = '0;
      b.mode = MODE_START;
    end
    return b;
  endfunction

  function automatic pstate_t take_octet(input pstate_t a, output logic ok);
    pstate_t b;
    b = a;
    ok = (a.gcnt != 3'd0) && (a.oacc <= 9'd255);
    if (ok) begin
      b.v4 = {a.v4[23:0], a.oacc[7:0]};
      b.oacc = '0;
      b.gcnt = '0;
    end
    return b;
  endfunction

  function automatic pstate_t fail(input pstate_t a);
    pstate_t b;
    b = a;
    if (a.err == STATUS_OK) b.err = STATUS_SYNTAX;
    return b;
  endfunction

  function automatic pstate_t finish(input pstate_t a);
    pstate_t b;
    pstate_t t;
    logic    ok;
    logic    bad;
    b = a;
    bad = 1'b0;
    if (a.err == STATUS_OK) begin
      if (a.mode == MODE_START) begin
        if (!a.seen_colon || a.prev_colon) bad = 1'b1;
      end else if (a.mode == MODE_DOT) begin
        t = take_octet(a, ok);
        if (a.ocnt != 2'd3 || !ok) bad = 1'b1;
        else if (!a.seen_colon) begin
          b = t;
          if (a.in_zone) b = fail(b);
        end else if (a.gidx > 4'd6) begin
          bad = 1'b1;
        end else begin
          b = t;
          b.groups[a.gidx[2:0]] = t.v4[31:16];
          b.groups[3'(a.gidx[2:0] + 3'd1)] = t.v4[15:0];
          b.gidx = a.gidx + 4'd2;
        end
      end else begin
        b = commit(a, ok);
        if (!ok) begin
          b = a;
          bad = 1'b1;
        end
      end
      if (bad) b = fail(a);
      else if (a.seen_colon || a.mode != MODE_DOT) begin
        if (b.cvalid ? (b.gidx > 4'd7) : (b.gidx != 4'd8)) b = fail(b);
      end
    end
    return b;
  endfunction

  assign hv  = hex_value(char_code);
  assign v   = hv[3:0];
  assign o10 = 12'(cur.oacc) * 12'd10 + 12'(v);

  always_comb begin
    logic ok;
    pstate_t t;
    s = cur;
    t = cur;
    ok = 1'b1;
    if (cur.in_zone) begin
      if (cur.zcnt != 8'hff) s.zcnt = cur.zcnt + 8'd1;
    end else if (char_code == CH_PERCENT) begin
      s.in_zone = 1'b1;
      if (reject_zone) s.err = STATUS_ZONE_NA;
      else s = finish(s);
    end else if (cur.err == STATUS_OK) begin
      if (char_code == CH_COLON) begin
        if (cur.mode == MODE_DOT) s = fail(cur);
        else if (cur.mode != MODE_START) begin
          t = commit(cur, ok);
          if (!ok) s = fail(cur);
          else begin
            s = t;
            s.prev_colon = 1'b1;
            s.seen_colon = 1'b1;
          end
        end else if (!cur.seen_colon) begin
          s.prev_colon = 1'b1;
          s.seen_colon = 1'b1;
        end else if (cur.prev_colon) begin
          if (cur.cvalid) s = fail(cur);
          else begin
            s.cvalid = 1'b1;
            s.cpos = cur.gidx[2:0];
            s.prev_colon = 1'b0;
          end
        end else begin
          s = fail(cur);
        end
      end else if (char_code == CH_DOT) begin
        if (cur.mode == MODE_DEC) begin
          t = take_octet(cur, ok);
          if (!ok) s = fail(cur);
          else begin
            s = t;
            s.ocnt = 2'd1;
            s.mode = MODE_DOT;
          end
        end else if (cur.mode == MODE_DOT) begin
          t = take_octet(cur, ok);
          if (cur.ocnt == 2'd3 || !ok) s = fail(cur);
          else begin
            s = t;
            s.ocnt = cur.ocnt + 2'd1;
          end
        end else begin
          s = fail(cur);
        end
      end else if (!hv[4]) begin
        if (cur.mode == MODE_DOT && v > 4'd9) s = fail(cur);
        else if (cur.mode != MODE_DOT && cur.mode == MODE_START && cur.prev_colon
                 && cur.gidx == 4'd0 && !cur.cvalid) s = fail(cur);
        else begin
          if (cur.mode != MODE_DOT) begin
            s.prev_colon = 1'b0;
            if (cur.gcnt < 3'd4) s.hacc = {cur.hacc[11:0], v};
            s.mode = (v > 4'd9 || cur.mode == MODE_HEX) ? MODE_HEX : MODE_DEC;
          end
          if (v <= 4'd9) s.oacc = (o10 > 12'd256) ? 9'd256 : o10[8:0];
          if (cur.gcnt != 3'd7) s.gcnt = cur.gcnt + 3'd1;
        end
      end else begin
        s = fail(cur);
      end
    end
  end

  // end of text
  always_comb begin
    f = s;
    if (!s.in_zone) f = finish(s);
    else if (s.zcnt == 8'd0) f = fail(s);
  end

  assign zsz = 4'd8 - f.gidx;

  always_comb begin
    full = '0;
    for (int g = 0; g < 8; g++) begin
      gsel = 4'(g) - zsz;
      if (!f.cvalid || 4'(g) < {1'b0, f.cpos}) word = f.groups[g];
      else if (4'(g) < {1'b0, f.cpos} + zsz) word = '0;
      else word = f.groups[gsel[2:0]];
      full[127 - 16*g -: 16] = word;
    end
  end

  always_comb begin
    res = '0;
    res.status = f.err;
    if (f.err == STATUS_OK) begin
      if (!f.seen_colon) begin
        res.addr_low = {32'd0, f.v4};
      end else begin
        res.is_ipv6 = 1'b1;
        res.addr_high = full[127:64];
        res.addr_low = full[63:0];
        res.has_zone = f.in_zone;
        res.zone_length = f.zcnt;
      end
    end
    nxt = last_char ? pstate_t'('0) : s;
  end

endmodule
